### rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants for the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4095;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 12'd480;

  localparam int MAG_W      = 11;
  localparam int ABS_W      = 10;
  localparam int SQ_W       = 21;
  localparam int ROOT_STEPS = 11;
  localparam int STEP_W     = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] red_mag;
    logic [MAG_W-1:0] green_mag;
    logic [MAG_W-1:0] blue_mag;
    logic             frame_last;
  } mag_out_t;

  typedef struct packed {
    logic load;
    logic square;
    logic step;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

### rtl/sgm_lane.sv
// ----------------------------------------------------------------------------
// sgm_lane
// One color channel: Sobel X/Y on a 3x3 window, square sum, iterative sqrt.
// ----------------------------------------------------------------------------
module sgm_lane (
  input  logic                            clk,
  input  sgm_pkg::lane_ctl_t              ctl,
  input  logic [8:0][7:0]                 win,
  input  logic [8:0]                      mask,
  output logic [sgm_pkg::MAG_W-1:0]       mag
);
  import sgm_pkg::*;

  logic [8:0][7:0]   v;
  logic [10:0]       xpos, xneg, ypos, yneg;
  logic signed [11:0] gx, gy;
  logic [11:0]       gx_abs, gy_abs;
  logic [ABS_W-1:0]  ax, ay;
  logic [2*ABS_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]   rem, res, bitv;
  logic [SQ_W:0]     trial;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      v[k] = mask[k] ? win[k] : win[4];
    end
    xpos = {3'b0, v[2]} + {2'b0, v[5], 1'b0} + {3'b0, v[8]};
    xneg = {3'b0, v[0]} + {2'b0, v[3], 1'b0} + {3'b0, v[6]};
    ypos = {3'b0, v[6]} + {2'b0, v[7], 1'b0} + {3'b0, v[8]};
    yneg = {3'b0, v[0]} + {2'b0, v[1], 1'b0} + {3'b0, v[2]};
    gx = $signed({1'b0, xpos}) - $signed({1'b0, xneg});
    gy = $signed({1'b0, ypos}) - $signed({1'b0, yneg});
    gx_abs = gx[11] ? 12'(-gx) : 12'(gx);
    gy_abs = gy[11] ? 12'(-gy) : 12'(gy);
    sqx = ax * ax;
    sqy = ay * ay;
    trial = {1'b0, res} + {1'b0, bitv};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ax <= gx_abs[ABS_W-1:0];
      ay <= gy_abs[ABS_W-1:0];
    end
    if (ctl.square) begin
      rem  <= {1'b0, sqx} + {1'b0, sqy};
      res  <= '0;
      bitv <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
    end else if (ctl.step) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign mag = res[MAG_W-1:0];

endmodule

### rtl/sgm_merge.sv
// ----------------------------------------------------------------------------
// sgm_merge
// Joins the three lane results and the frame flag into the output register.
// ----------------------------------------------------------------------------
module sgm_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [sgm_pkg::MAG_W-1:0]   red,
  input  logic [sgm_pkg::MAG_W-1:0]   green,
  input  logic [sgm_pkg::MAG_W-1:0]   blue,
  input  logic                        last,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sgm_pkg::mag_out_t           out_data
);
  import sgm_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.red_mag    <= red;
      out_data.green_mag  <= green;
      out_data.blue_mag   <= blue;
      out_data.frame_last <= last;
    end
  end

endmodule

### rtl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 Sobel gradient magnitude per RGB channel on a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in      | in  | kind, red_in, green_in, blue_in
//  out     | out | red_mag, green_mag, blue_mag, frame_last
//  cfg     | in  | cfg_index, cfg_data (0 image_width, 1 image_height)
//
// One word at a time. A word that yields no result goes through the row
// buffer read, then write and window shift. A word with a result also
// runs the 11-step shared-nothing square root in each lane.
// No clearing pass after reset. A stalled output holds one result while
// the next word is accepted; a second result waits for the first.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sgm_pkg::pixel_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sgm_pkg::mag_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sgm_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  state_t state, state_next;
  lane_ctl_t ctl;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  logic [CW-1:0] in_column, in_column_next;
  logic [RW-1:0] in_row, in_row_next;

  logic [23:0] mem_upper  [MAX_WIDTH];
  logic [23:0] mem_middle [MAX_WIDTH];
  logic [23:0] top_q, mid_q;

  logic [23:0] win [3][3];

  logic [AW-1:0] col_q;
  logic [23:0]   bottom_q;
  logic          emit_q, last_q;
  logic [8:0]    mask_q;
  logic [STEP_W-1:0] step_cnt;

  logic          accept, skip, draining, emit, last;
  logic [CW-1:0] cc;
  logic [RW-1:0] rc;
  logic [2:0]    row_ok, col_ok;
  logic [8:0]    mask;
  logic [CW-1:0] col_inc;
  logic [RW-1:0] row_inc;

  logic [8:0][7:0] win_r, win_g, win_b;
  logic [MAG_W-1:0] mag_r, mag_g, mag_b;
  logic merge_load, merge_free;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    draining = in_row >= h_eff;
    skip     = in_data.kind && !draining;
    emit     = (in_row >= RW'(2)) || (in_row == RW'(1) && in_column != '0);
    if (in_column == '0) begin
      cc = w_eff - CW'(1);
      rc = in_row - RW'(2);
    end else begin
      cc = in_column - CW'(1);
      rc = in_row - RW'(1);
    end
    row_ok = {(rc + RW'(1)) < h_eff, 1'b1, rc != '0};
    col_ok = {(cc + CW'(1)) < w_eff, 1'b1, cc != '0};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask[i*3+j] = row_ok[i] & col_ok[j];
      end
    end
    last = emit && (rc == h_eff - RW'(1)) && (cc == w_eff - CW'(1));

    col_inc = in_column + CW'(1);
    row_inc = in_row;
    if (col_inc >= w_eff) begin
      col_inc = '0;
      row_inc = in_row + RW'(1);
    end
    if (last || row_inc > h_eff + RW'(1)) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else begin
      in_column_next = col_inc;
      in_row_next    = row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      in_column    <= '0;
      in_row       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[CFG_WIDTH_W-1:0];
          in_column   <= '0;
          in_row      <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[CFG_HEIGHT_W-1:0];
          in_column    <= '0;
          in_row       <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept && !skip) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  // item latch and row buffer read
  always_ff @(posedge clk) begin
    if (accept && !skip) begin
      col_q    <= in_column[AW-1:0];
      bottom_q <= draining ? 24'd0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
      emit_q   <= emit;
      last_q   <= last;
      mask_q   <= mask;
      top_q    <= mem_upper[in_column[AW-1:0]];
      mid_q    <= mem_middle[in_column[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      mem_upper[col_q]  <= mid_q;
      mem_middle[col_q] <= bottom_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (state == ST_READ) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= top_q;
      win[1][2] <= mid_q;
      win[2][2] <= bottom_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_r[i*3+j] = win[i][j][23:16];
        win_g[i*3+j] = win[i][j][15:8];
        win_b[i*3+j] = win[i][j][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SQUARE) begin
        step_cnt <= '0;
      end else if (state == ST_ROOT) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    merge_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && !skip) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = emit_q ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        ctl.load   = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        ctl.square = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        ctl.step = 1'b1;
        if (step_cnt == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  sgm_lane u_lane_r (.clk(clk), .ctl(ctl), .win(win_r), .mask(mask_q), .mag(mag_r));
  sgm_lane u_lane_g (.clk(clk), .ctl(ctl), .win(win_g), .mask(mask_q), .mag(mag_g));
  sgm_lane u_lane_b (.clk(clk), .ctl(ctl), .win(win_b), .mask(mask_q), .mag(mag_b));

  sgm_merge u_merge (
    .clk(clk), .rst(rst), .load(merge_load),
    .red(mag_r), .green(mag_g), .blue(mag_b), .last(last_q),
    .free(merge_free), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (accept && !skip) |=> (state == ST_READ))
    else $error("accepted word did not start a buffer read");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> (step_cnt < STEP_W'(ROOT_STEPS)))
    else $error("root step count overran");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    merge_load |-> (!out_valid || out_ready))
    else $error("result overwrote a pending word");

  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    (merge_load && last_q) |-> (in_row == '0 && in_column == '0))
    else $error("frame end did not restart position");

endmodule
